/* src/arcc_pkg.sv */
// Shared types, codes and defaults for the ARP reply count classifier.
package arcc_pkg;

  // Default number of table entries
  localparam int unsigned TABLE_DEPTH_DEF = 16;

  // Field widths
  localparam int unsigned IP_W    = 32;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CFG_W   = 16;

  // Saturation value of a reply count
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Threshold reset values
  localparam logic [CFG_W-1:0] ATTACK_THR_RST = 16'd10;
  localparam logic [CFG_W-1:0] SUSP_THR_RST   = 16'd3;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_ATTACK_THR = 1'b0,
    CFG_SUSP_THR   = 1'b1
  } cfg_idx_t;

  // Commands
  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_EXISTS = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  // Verdict codes
  localparam logic [1:0] VERDICT_NORMAL     = 2'd0;
  localparam logic [1:0] VERDICT_SUSPICIOUS = 2'd1;
  localparam logic [1:0] VERDICT_ATTACK     = 2'd2;

  // One table entry
  typedef struct packed {
    logic [IP_W-1:0]    ip;
    logic [COUNT_W-1:0] count;
  } entry_t;

endpackage

/* src/arcc_if.sv */
// Valid/ready channel interfaces for commands and results.
interface arcc_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic [arcc_pkg::IP_W-1:0]     ip_addr;

  modport source (output valid, output command, output ip_addr, input ready);
  modport sink   (input valid, input command, input ip_addr, output ready);
endinterface

interface arcc_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [1:0] verdict;
  logic       table_full;

  modport source (output valid, output found, output verdict, output table_full, input ready);
  modport sink   (input valid, input found, input verdict, input table_full, output ready);
endinterface

/* src/arp_reply_count_classifier_core.sv */
// Top level: ARP reply counter table with threshold classification.
//
//  channel  | direction | handshake     | payload
//  ---------+-----------+---------------+-------------------------------
//  in_ch    | in        | valid/ready   | command[1:0], ip_addr[31:0]
//  out_ch   | out       | valid/ready   | found, verdict[1:0], table_full
//  cfg_*    | in        | cfg_we only   | cfg_idx[0], cfg_wdata[15:0]
//
// One command at a time. An accepted command scans the table from entry 0 until
// it finds a match or passes the last entry, one memory read per cycle (none
// on an empty table); delete then moves each later entry down one place, and
// add appends a new entry with a count of one, or flags a full table.
// The next command is accepted in the cycle after the result is loaded.
// Reset clears the fill count and sets the thresholds to their reset values; the table itself is not cleared.
// A result waits in the output register while out_ch.ready is low; the next
// command is accepted meanwhile and holds in its last step until it frees.
module arp_reply_count_classifier_core #(
  parameter int unsigned TABLE_DEPTH = arcc_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  arcc_in_if.sink                    in_ch,
  arcc_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [0:0]                 cfg_idx,
  input  logic [arcc_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_APPEND,
    ST_FINISH
  } state_t;

  state_t                        state_r;
  arcc_pkg::cmd_t                cmd_r;
  logic [arcc_pkg::IP_W-1:0]     ip_r;
  logic [IDX_W-1:0]              idx_r;
  logic [CNT_W-1:0]              used_r;
  logic                          res_found_r;
  logic [1:0]                    res_verdict_r;
  logic                          res_full_r;
  logic                          out_valid_r;
  logic                          out_found_r;
  logic [1:0]                    out_verdict_r;
  logic                          out_full_r;
  logic [arcc_pkg::CFG_W-1:0]    attack_thr_r;
  logic [arcc_pkg::CFG_W-1:0]    susp_thr_r;

  // Table memory
  arcc_pkg::entry_t              mem [TABLE_DEPTH];
  arcc_pkg::entry_t              rd_data_r;
  logic                          rd_en;
  logic [IDX_W-1:0]              rd_idx;
  logic                          wr_en;
  logic [IDX_W-1:0]              wr_idx;
  arcc_pkg::entry_t              wr_data;

  logic                          in_accept;
  logic                          out_load;
  logic                          more;
  logic                          match;
  logic [arcc_pkg::COUNT_W-1:0]  cnt_inc;
  logic [1:0]                    verdict_calc;
  logic                          room;

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign in_accept         = in_ch.valid && in_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.found      = out_found_r;
  assign out_ch.verdict    = out_verdict_r;
  assign out_ch.table_full = out_full_r;

  // Finished result moves into the output register when it is free or being taken
  assign out_load = (state_r == ST_FINISH) && (!out_valid_r || out_ch.ready);

  // Scan helpers
  assign more  = (CNT_W'(idx_r) + CNT_W'(1)) < used_r;
  assign match = (rd_data_r.ip == ip_r);
  assign room  = used_r < DEPTH_C;
  assign cnt_inc = (rd_data_r.count == arcc_pkg::COUNT_MAX)
                   ? rd_data_r.count
                   : rd_data_r.count + arcc_pkg::COUNT_W'(1);

  // Classification, attack first
  always_comb begin
    priority if (cnt_inc >= attack_thr_r) begin
      verdict_calc = arcc_pkg::VERDICT_ATTACK;
    end else if (cnt_inc >= susp_thr_r) begin
      verdict_calc = arcc_pkg::VERDICT_SUSPICIOUS;
    end else begin
      verdict_calc = arcc_pkg::VERDICT_NORMAL;
    end
  end

  // Memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_idx  = '0;
    wr_en   = 1'b0;
    wr_idx  = '0;
    wr_data = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && (used_r != '0)) begin
          rd_en = 1'b1;
        end
      end
      ST_SEARCH: begin
        if (match) begin
          if (cmd_r == arcc_pkg::CMD_UPDATE) begin
            wr_en   = 1'b1;
            wr_idx  = idx_r;
            wr_data = '{ip: ip_r, count: cnt_inc};
          end
          if ((cmd_r == arcc_pkg::CMD_DELETE) && more) begin
            rd_en  = 1'b1;
            rd_idx = idx_r + IDX_W'(1);
          end
        end else if (more) begin
          rd_en  = 1'b1;
          rd_idx = idx_r + IDX_W'(1);
        end
      end
      ST_SHIFT: begin
        // move entry idx down one place, closing the gap
        wr_en   = 1'b1;
        wr_idx  = idx_r - IDX_W'(1);
        wr_data = rd_data_r;
        if (more) begin
          rd_en  = 1'b1;
          rd_idx = idx_r + IDX_W'(1);
        end
      end
      ST_APPEND: begin
        if (room) begin
          wr_en   = 1'b1;
          wr_idx  = used_r[IDX_W-1:0];
          wr_data = '{ip: ip_r, count: arcc_pkg::COUNT_W'(1)};
        end
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // Synchronous memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_thr_r <= arcc_pkg::ATTACK_THR_RST;
      susp_thr_r   <= arcc_pkg::SUSP_THR_RST;
    end else if (cfg_we) begin
      unique case (arcc_pkg::cfg_idx_t'(cfg_idx))
        arcc_pkg::CFG_ATTACK_THR: attack_thr_r <= cfg_wdata;
        arcc_pkg::CFG_SUSP_THR:   susp_thr_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Command sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            cmd_r         <= arcc_pkg::cmd_t'(in_ch.command);
            ip_r          <= in_ch.ip_addr;
            idx_r         <= '0;
            res_found_r   <= 1'b0;
            res_verdict_r <= arcc_pkg::VERDICT_NORMAL;
            res_full_r    <= 1'b0;
            if (used_r != '0) begin
              state_r <= ST_SEARCH;
            end else if (arcc_pkg::cmd_t'(in_ch.command) == arcc_pkg::CMD_ADD) begin
              state_r <= ST_APPEND;
            end else begin
              state_r <= ST_FINISH;
            end
          end
        end
        ST_SEARCH: begin
          if (match) begin
            res_found_r <= 1'b1;
            unique case (cmd_r)
              arcc_pkg::CMD_ADD:    state_r <= ST_APPEND;
              arcc_pkg::CMD_EXISTS: state_r <= ST_FINISH;
              arcc_pkg::CMD_UPDATE: begin
                res_verdict_r <= verdict_calc;
                state_r       <= ST_FINISH;
              end
              arcc_pkg::CMD_DELETE: begin
                if (more) begin
                  idx_r   <= idx_r + IDX_W'(1);
                  state_r <= ST_SHIFT;
                end else begin
                  used_r  <= used_r - CNT_W'(1);
                  state_r <= ST_FINISH;
                end
              end
              default: state_r <= ST_FINISH;
            endcase
          end else if (more) begin
            idx_r <= idx_r + IDX_W'(1);
          end else if (cmd_r == arcc_pkg::CMD_ADD) begin
            state_r <= ST_APPEND;
          end else begin
            state_r <= ST_FINISH;
          end
        end
        ST_SHIFT: begin
          if (more) begin
            idx_r <= idx_r + IDX_W'(1);
          end else begin
            used_r  <= used_r - CNT_W'(1);
            state_r <= ST_FINISH;
          end
        end
        ST_APPEND: begin
          if (room) begin
            used_r <= used_r + CNT_W'(1);
          end else begin
            res_full_r <= 1'b1;
          end
          state_r <= ST_FINISH;
        end
        ST_FINISH: begin
          // hand over once the output register is free or being emptied
          if (out_load) begin
            out_found_r   <= res_found_r;
            out_verdict_r <= res_verdict_r;
            out_full_r    <= res_full_r;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* src/arcc_checker.sv */
// Port-level assertions for the classifier core, bound to the top level.
module arcc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_found,
  input logic [1:0] out_verdict,
  input logic       out_table_full
);

  // A result transaction stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_found) && $stable(out_verdict)
                               && $stable(out_table_full))
    else $error("stalled result changed");

  // A raised verdict needs a matching entry
  a_verdict_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_verdict != arcc_pkg::VERDICT_NORMAL) |-> out_found)
    else $error("non-normal verdict without a matching entry");

  // A dropped add carries no verdict, and no code beyond attack appears
  a_full_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict == arcc_pkg::VERDICT_NORMAL && out_table_full)
               || (out_verdict == arcc_pkg::VERDICT_NORMAL)
               || (out_verdict == arcc_pkg::VERDICT_SUSPICIOUS && !out_table_full)
               || (out_verdict == arcc_pkg::VERDICT_ATTACK && !out_table_full))
    else $error("illegal verdict or verdict on a dropped add");

endmodule

bind arp_reply_count_classifier_core arcc_checker u_arcc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_found      (out_ch.found),
  .out_verdict    (out_ch.verdict),
  .out_table_full (out_ch.table_full)
);

/* verif/arp_reply_count_classifier_core_tb.sv */
// Self-checking testbench for the ARP reply counter table and its threshold verdicts.
`timescale 1ns / 100ps

module arp_reply_count_classifier_core_tb;

  localparam int DEPTH        = arcc_pkg::TABLE_DEPTH_DEF;
  localparam int IDLE_PCT     = 15;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int POOL_SIZE    = 8;
  localparam int RAND_ITEMS   = 320;
  localparam logic [arcc_pkg::IP_W-1:0] IP_LO = '0;
  localparam logic [arcc_pkg::IP_W-1:0] IP_HI = '1;

  typedef struct packed {
    logic       found;
    logic [1:0] verdict;
    logic       table_full;
  } reply_t;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       cfg_we    = 1'b0;
  logic [0:0]                 cfg_idx   = '0;
  logic [arcc_pkg::CFG_W-1:0] cfg_wdata = '0;

  arcc_in_if  in_if ();
  arcc_out_if out_if ();

  arp_reply_count_classifier_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Shadow copy of the table, its fill count and the thresholds
  logic [arcc_pkg::IP_W-1:0]    tbl_ip    [DEPTH];
  logic [arcc_pkg::COUNT_W-1:0] tbl_count [DEPTH];
  int                           tbl_used   = 0;
  logic [arcc_pkg::CFG_W-1:0]   thr_attack = arcc_pkg::ATTACK_THR_RST;
  logic [arcc_pkg::CFG_W-1:0]   thr_susp   = arcc_pkg::SUSP_THR_RST;

  reply_t                    pending_replies [$];
  logic [arcc_pkg::IP_W-1:0] ip_pool [POOL_SIZE];
  int                        n_errors    = 0;
  int                        cycle_count = 0;
  bit                        idle_on     = 1'b1;
  int                        hold_req    = 0;
  int                        hold_left   = 0;

  // Apply one command to the shadow table and return the reply it should give
  function automatic reply_t predict_reply(arcc_pkg::cmd_t cmd,
                                           logic [arcc_pkg::IP_W-1:0] ip);
    reply_t r;
    int     hit;
    r            = '0;
    r.verdict    = arcc_pkg::VERDICT_NORMAL;
    hit          = tbl_used;
    for (int k = tbl_used - 1; k >= 0; k--) begin
      if (tbl_ip[k] == ip) hit = k;
    end
    r.found = (hit < tbl_used);
    case (cmd)
      arcc_pkg::CMD_ADD: begin
        if (tbl_used < DEPTH) begin
          tbl_ip[tbl_used]    = ip;
          tbl_count[tbl_used] = 1;
          tbl_used++;
        end else begin
          r.table_full = 1'b1;
        end
      end
      arcc_pkg::CMD_UPDATE: begin
        if (r.found) begin
          if (tbl_count[hit] != arcc_pkg::COUNT_MAX) tbl_count[hit]++;
          // attack is tested first, so reversed thresholds still give attack
          if (tbl_count[hit] >= thr_attack) r.verdict = arcc_pkg::VERDICT_ATTACK;
          else if (tbl_count[hit] >= thr_susp) r.verdict = arcc_pkg::VERDICT_SUSPICIOUS;
        end
      end
      arcc_pkg::CMD_DELETE: begin
        if (r.found) begin
          for (int k = hit; k < tbl_used - 1; k++) begin
            tbl_ip[k]    = tbl_ip[k + 1];
            tbl_count[k] = tbl_count[k + 1];
          end
          tbl_used--;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one command, with random idle cycles first; valid stays high on return
  task automatic send_cmd(arcc_pkg::cmd_t cmd, logic [arcc_pkg::IP_W-1:0] ip);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid   <= 1'b1;
    in_if.command <= cmd;
    in_if.ip_addr <= ip;
    do begin
      @(posedge clk);
    end while (!in_if.ready);
    pending_replies.push_back(predict_reply(cmd, ip));
  endtask

  // Stop offering and wait until every reply is in and the block has settled
  task automatic quiesce();
    @(negedge clk);
    in_if.valid <= 1'b0;
    wait (pending_replies.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(arcc_pkg::cfg_idx_t idx, logic [arcc_pkg::CFG_W-1:0] val);
    quiesce();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      arcc_pkg::CFG_ATTACK_THR: thr_attack = val;
      arcc_pkg::CFG_SUSP_THR:   thr_susp   = val;
      default: ;
    endcase
  endtask

  task automatic set_thresholds(logic [arcc_pkg::CFG_W-1:0] attack,
                                logic [arcc_pkg::CFG_W-1:0] susp);
    write_cfg(arcc_pkg::CFG_ATTACK_THR, attack);
    write_cfg(arcc_pkg::CFG_SUSP_THR, susp);
  endtask

  // Delete the oldest entry until the table is empty
  task automatic clear_table();
    while (tbl_used > 0) send_cmd(arcc_pkg::CMD_DELETE, tbl_ip[0]);
  endtask

  // Every command at the reset thresholds, hits and misses, both address extremes
  task automatic test_defaults();
    send_cmd(arcc_pkg::CMD_ADD, IP_LO);
    send_cmd(arcc_pkg::CMD_EXISTS, IP_LO);
    send_cmd(arcc_pkg::CMD_EXISTS, IP_HI);
    send_cmd(arcc_pkg::CMD_UPDATE, IP_LO);
    send_cmd(arcc_pkg::CMD_UPDATE, IP_LO);
    send_cmd(arcc_pkg::CMD_UPDATE, IP_HI);
    send_cmd(arcc_pkg::CMD_DELETE, IP_HI);
    repeat (7) send_cmd(arcc_pkg::CMD_UPDATE, IP_LO);
    send_cmd(arcc_pkg::CMD_DELETE, IP_LO);
    send_cmd(arcc_pkg::CMD_EXISTS, IP_LO);
  endtask

  // Duplicate adds, add to a full table, delete of the oldest in a full table
  task automatic test_table_full();
    send_cmd(arcc_pkg::CMD_ADD, IP_HI);
    send_cmd(arcc_pkg::CMD_ADD, IP_HI);
    repeat (DEPTH - 2) send_cmd(arcc_pkg::CMD_ADD, $urandom);
    send_cmd(arcc_pkg::CMD_ADD, IP_LO);
    send_cmd(arcc_pkg::CMD_DELETE, IP_HI);
    send_cmd(arcc_pkg::CMD_UPDATE, IP_HI);
    send_cmd(arcc_pkg::CMD_EXISTS, IP_LO);
  endtask

  // Reversed thresholds, zero thresholds and an update miss under them
  task automatic test_threshold_order();
    logic [arcc_pkg::IP_W-1:0] ip;
    ip = $urandom;
    set_thresholds(2, 5);
    clear_table();
    send_cmd(arcc_pkg::CMD_ADD, ip);
    send_cmd(arcc_pkg::CMD_UPDATE, ip);
    set_thresholds(0, 0);
    send_cmd(arcc_pkg::CMD_UPDATE, ip);
    send_cmd(arcc_pkg::CMD_UPDATE, ~ip);
    set_thresholds(40, 0);
    send_cmd(arcc_pkg::CMD_UPDATE, ip);
    set_thresholds(1, 1);
    send_cmd(arcc_pkg::CMD_ADD, IP_HI);
    send_cmd(arcc_pkg::CMD_UPDATE, IP_HI);
  endtask

  // A long run of updates on one entry across high thresholds, no idling
  task automatic test_high_count();
    logic [arcc_pkg::IP_W-1:0] ip;
    ip = $urandom;
    set_thresholds(250, 200);
    idle_on = 1'b0;
    clear_table();
    send_cmd(arcc_pkg::CMD_ADD, ip);
    repeat (250) send_cmd(arcc_pkg::CMD_UPDATE, ip);
    send_cmd(arcc_pkg::CMD_EXISTS, ip);
    idle_on = 1'b1;
  endtask

  // Long receiver hold-off while commands keep coming, then a full drain
  task automatic test_backpressure();
    hold_req = 250;
    repeat (12) send_cmd(arcc_pkg::cmd_t'($urandom_range(3)),
                         ip_pool[$urandom_range(POOL_SIZE - 1)]);
    quiesce();
  endtask

  // Random commands steered by the fill level, mostly on known addresses
  task automatic test_random(int n_items, logic [arcc_pkg::CFG_W-1:0] attack,
                             logic [arcc_pkg::CFG_W-1:0] susp, bit idle);
    int                        r;
    int                        add_w;
    int                        del_w;
    arcc_pkg::cmd_t            cmd;
    logic [arcc_pkg::IP_W-1:0] ip;
    set_thresholds(attack, susp);
    idle_on = idle;
    for (int i = 0; i < n_items; i++) begin
      add_w = (tbl_used < 4) ? 45 : ((tbl_used > DEPTH - 3) ? 10 : 25);
      del_w = (tbl_used > DEPTH - 3) ? 35 : 15;
      r     = $urandom_range(99);
      if (r < add_w) cmd = arcc_pkg::CMD_ADD;
      else if (r < add_w + del_w) cmd = arcc_pkg::CMD_DELETE;
      else if (r < add_w + del_w + 15) cmd = arcc_pkg::CMD_EXISTS;
      else cmd = arcc_pkg::CMD_UPDATE;
      r = $urandom_range(99);
      // occasional unknown address as noise
      if (r < 10) ip = $urandom;
      else if (cmd != arcc_pkg::CMD_ADD && tbl_used > 0 && r < 75)
        ip = tbl_ip[$urandom_range(tbl_used - 1)];
      else ip = ip_pool[$urandom_range(POOL_SIZE - 1)];
      send_cmd(cmd, ip);
    end
    idle_on = 1'b1;
  endtask

  // Receiver: random stalls, or a counted hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_req > 0) begin
      out_if.ready <= 1'b0;
      hold_left = hold_req - 1;
      hold_req  = 0;
    end else begin
      out_if.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  // Reply checker: each transaction against the oldest expectation
  always @(posedge clk) begin : reply_check
    reply_t got;
    reply_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{found: out_if.found, verdict: out_if.verdict, table_full: out_if.table_full};
      if (pending_replies.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("cycle %0d: reply with none expected: found=%0b verdict=%0d full=%0b",
                   cycle_count, got.found, got.verdict, got.table_full);
      end else begin
        want = pending_replies.pop_front();
        if (got.found !== want.found || got.verdict !== want.verdict ||
            got.table_full !== want.table_full) begin
          n_errors++;
          if (n_errors <= 10)
            $display("cycle %0d: expected found=%0b verdict=%0d full=%0b, got %0b %0d %0b",
                     cycle_count, want.found, want.verdict, want.table_full,
                     got.found, got.verdict, got.table_full);
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("arp_reply_count_classifier_core_tb: done, errors");
      $finish;
    end
  end

  initial begin
    in_if.valid   = 1'b0;
    in_if.command = arcc_pkg::CMD_ADD;
    in_if.ip_addr = '0;
    ip_pool[0]    = IP_LO;
    ip_pool[1]    = IP_HI;
    for (int k = 2; k < POOL_SIZE; k++) ip_pool[k] = $urandom;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_defaults();
    test_table_full();
    test_threshold_order();
    test_backpressure();
    test_high_count();
    test_random(RAND_ITEMS, 12, 4, 1'b1);
    test_random(RAND_ITEMS, 6, 9, 1'b1);
    test_backpressure();
    test_random(RAND_ITEMS, 25, 2, 1'b0);
    test_random(RAND_ITEMS, arcc_pkg::CFG_W'($urandom_range(1, 40)),
                arcc_pkg::CFG_W'($urandom_range(1, 40)), 1'b1);
    quiesce();

    if (n_errors == 0) begin
      $display("arp_reply_count_classifier_core_tb: done, clean");
    end else begin
      $display("arp_reply_count_classifier_core_tb: done, errors");
    end
    $finish;
  end

endmodule
